// ===== hw/rtl/kuf_pkg.sv =====
// Package for the union-find edge filter: widths, store entry layout,
// action codes and controller state type. No dependencies.
package kuf_pkg;

  localparam int NODES    = 128;
  localparam int NODE_W   = $clog2(NODES);
  localparam int SIZE_W   = $clog2(NODES) + 1;
  localparam int WEIGHT_W = 32;

  // Item action codes
  localparam logic ACT_CLEAR = 1'b0;
  localparam logic ACT_EDGE  = 1'b1;

  // One store entry: root mark, parent link, set size (valid at roots only)
  typedef struct packed {
    logic              is_root;
    logic [NODE_W-1:0] parent;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FIND  = 5'b00010,
    S_COMP  = 5'b00100,
    S_MERGE = 5'b01000,
    S_SIZE  = 5'b10000
  } state_t;

endpackage

// ===== hw/rtl/kruskal_union_find_edge_filter.sv =====
// Top level of the union-find edge filter: controller plus node store.
// Depends on kuf_pkg.
//
// Union-find engine for Kruskal's rule. A start with action 0 clears every set to a
// singleton; a start with action 1 offers an edge (node_a, node_b, weight). Each
// transaction returns exactly one result, shown for one cycle with done high; the
// receiver cannot stall it. A clear or a zero-weight edge answers in the cycle after
// start. A real edge walks node_a's parent chain, rewrites that path to point at
// the root, does the same for node_b, then merges by size. The single node store
// delivers one entry per cycle through a registered read port. Busy is high while
// an edge is being worked; the next start may come in the cycle its result shows.
module kruskal_union_find_edge_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action,
  input  logic [kuf_pkg::NODE_W-1:0]    node_a,
  input  logic [kuf_pkg::NODE_W-1:0]    node_b,
  input  logic [kuf_pkg::WEIGHT_W-1:0]  weight,
  output logic                          done,
  output logic                          accepted,
  output logic [kuf_pkg::NODE_W-1:0]    tree_a,
  output logic [kuf_pkg::NODE_W-1:0]    tree_b,
  output logic [kuf_pkg::WEIGHT_W-1:0]  tree_weight
);
  import kuf_pkg::*;

  // Node store and its entry valid bits (invalid entry reads as singleton root)
  entry_t            mem [NODES];
  logic [NODES-1:0]  valid;
  entry_t            rd_q;
  logic              rd_valid;

  // Store port controls
  logic              we;
  logic [NODE_W-1:0] waddr;
  entry_t            wdata;
  logic [NODE_W-1:0] raddr;
  logic              clear_all;

  // Controller registers
  state_t              state, state_next;
  logic                side, side_next;
  logic [NODE_W-1:0]   cur, cur_next;
  logic [NODE_W-1:0]   a_q, b_q;
  logic [WEIGHT_W-1:0] w_q;
  logic [NODE_W-1:0]   ra, rb;
  logic [SIZE_W-1:0]   sa, sb;

  // Decoded entry of node cur
  logic              ent_root;
  logic [NODE_W-1:0] ent_parent;
  logic [SIZE_W-1:0] ent_size;
  logic [NODE_W-1:0] root_cur;
  logic [NODE_W-1:0] start_cur;
  logic              a_wins;
  logic              take;

  assign ent_root   = !rd_valid || rd_q.is_root;
  assign ent_parent = rd_q.parent;
  assign ent_size   = rd_valid ? rd_q.size : SIZE_W'(1);
  assign root_cur   = side ? rb : ra;
  assign start_cur  = side ? b_q : a_q;
  // Larger set wins; on a tie node_a's root stays the root
  assign a_wins     = !(sa < sb);
  assign take       = start && !busy;
  assign busy       = (state != S_IDLE);
  assign raddr      = cur_next;

  // Next state and store access
  always_comb begin
    state_next = state;
    side_next  = side;
    cur_next   = cur;
    we         = 1'b0;
    waddr      = cur;
    wdata      = '{is_root: 1'b0, parent: root_cur, size: rd_q.size};
    clear_all  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          if (action == ACT_CLEAR) begin
            clear_all = 1'b1;
          end else if (weight != '0) begin
            cur_next   = node_a;
            side_next  = 1'b0;
            state_next = S_FIND;
          end
        end
      end
      S_FIND: begin
        if (ent_root) begin
          cur_next   = start_cur;
          state_next = S_COMP;
        end else begin
          cur_next = ent_parent;
        end
      end
      S_COMP: begin
        if (cur == root_cur || ent_root) begin
          if (!side) begin
            side_next  = 1'b1;
            cur_next   = b_q;
            state_next = S_FIND;
          end else begin
            state_next = S_MERGE;
          end
        end else begin
          // point this node straight at its root, move on to its old parent
          we       = 1'b1;
          waddr    = cur;
          cur_next = ent_parent;
        end
      end
      S_MERGE: begin
        if (ra == rb) begin
          state_next = S_IDLE;
        end else begin
          we         = 1'b1;
          waddr      = a_wins ? rb : ra;
          wdata      = '{is_root: 1'b0, parent: (a_wins ? ra : rb), size: '0};
          state_next = S_SIZE;
        end
      end
      S_SIZE: begin
        we         = 1'b1;
        waddr      = a_wins ? ra : rb;
        wdata      = '{is_root: 1'b1, parent: '0, size: SIZE_W'(sa + sb)};
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Store: write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // Valid bits and registered valid of the read entry
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rd_valid <= valid[raddr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      side  <= 1'b0;
      cur   <= '0;
    end else begin
      state <= state_next;
      side  <= side_next;
      cur   <= cur_next;
    end
  end

  // Transaction payload and found roots
  always_ff @(posedge clk) begin
    if (take) begin
      a_q <= node_a;
      b_q <= node_b;
      w_q <= weight;
    end
    if (state == S_FIND && ent_root) begin
      if (side) begin
        rb <= cur;
        sb <= ent_size;
      end else begin
        ra <= cur;
        sa <= ent_size;
      end
    end
  end

  // Result strobe and fields
  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      accepted <= 1'b0;
    end else begin
      done     <= 1'b0;
      accepted <= 1'b0;
      if (take && (action == ACT_CLEAR || weight == '0)) begin
        done <= 1'b1;
      end else if (state == S_MERGE && ra == rb) begin
        done <= 1'b1;
      end else if (state == S_SIZE) begin
        done     <= 1'b1;
        accepted <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SIZE) begin
      tree_a      <= a_q;
      tree_b      <= b_q;
      tree_weight <= w_q;
    end else begin
      tree_a      <= '0;
      tree_b      <= '0;
      tree_weight <= '0;
    end
  end

`ifndef SYNTHESIS
  // No store write outside an edge transaction
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !we) else $error("store written while idle");

  // Path rewrite never reads the entry it writes
  a_comp_no_alias: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMP && we) |-> waddr != raddr) else $error("rewrite aliasing");

  // A merge only links two distinct roots
  a_merge_distinct: assert property (@(posedge clk) disable iff (rst)
    state == S_SIZE |-> ra != rb) else $error("merge of one root");

  // A real edge always starts a walk
  a_edge_walks: assert property (@(posedge clk) disable iff (rst)
    (take && action == ACT_EDGE && weight != '0) |=> state == S_FIND)
    else $error("edge did not start a walk");

  // An accepted result follows the size update
  a_accept_after_size: assert property (@(posedge clk) disable iff (rst)
    accepted |-> done && $past(state) == S_SIZE) else $error("stray accept");
`endif

endmodule

// ===== test/kruskal_union_find_edge_filter_tb.sv =====
// Testbench for kruskal_union_find_edge_filter: directed and random edge streams,
// checked against an in-bench union-find predictor. Depends on kuf_pkg and the RTL.
`timescale 1ns / 100ps

module kruskal_union_find_edge_filter_tb;
  import kuf_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic                acc;
    logic [NODE_W-1:0]   ta;
    logic [NODE_W-1:0]   tb;
    logic [WEIGHT_W-1:0] tw;
  } verdict_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                action = ACT_CLEAR;
  logic [NODE_W-1:0]   node_a = '0;
  logic [NODE_W-1:0]   node_b = '0;
  logic [WEIGHT_W-1:0] weight = '0;
  logic                busy;
  logic                done;
  logic                accepted;
  logic [NODE_W-1:0]   tree_a;
  logic [NODE_W-1:0]   tree_b;
  logic [WEIGHT_W-1:0] tree_weight;

  // predictor copy of the node store
  int       link_to [NODES];
  bit       is_root [NODES];
  int       grp_size [NODES];
  verdict_t pending_verdicts [$];

  int idle_pct = 0;
  int cycle_count = 0;
  int n_offered = 0;
  int n_tree_edges = 0;
  int n_rejected = 0;
  int n_clears = 0;
  int n_mismatch = 0;

  kruskal_union_find_edge_filter uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .node_a(node_a), .node_b(node_b), .weight(weight), .done(done),
    .accepted(accepted), .tree_a(tree_a), .tree_b(tree_b), .tree_weight(tree_weight)
  );

  always #6 clk = ~clk;

  // run-time guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at %0t after %0d cycles", $time, cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void reset_sets();
    for (int i = 0; i < NODES; i++) begin
      link_to[i] = 0;
      is_root[i] = 1'b1;
      grp_size[i] = 1;
    end
  endfunction

  // walk to the root, then point the walked path straight at it
  function automatic int find_set_root(int node);
    int r, cur, nxt, steps;
    r = node;
    steps = 0;
    while (!is_root[r] && steps < NODES) begin
      r = link_to[r] % NODES;
      steps++;
    end
    cur = node;
    steps = 0;
    while (cur != r && !is_root[cur] && steps < NODES) begin
      nxt = link_to[cur] % NODES;
      link_to[cur] = r;
      cur = nxt;
      steps++;
    end
    return r;
  endfunction

  function automatic verdict_t judge_edge(logic act, logic [NODE_W-1:0] a,
                                          logic [NODE_W-1:0] b, logic [WEIGHT_W-1:0] w);
    verdict_t v;
    int ra, rb;
    v = '0;
    if (act == ACT_CLEAR) begin
      reset_sets();
      return v;
    end
    if (w == 0 || a >= NODES || b >= NODES) return v;
    ra = find_set_root(int'(a));
    rb = find_set_root(int'(b));
    if (ra == rb) return v;
    // smaller set joins larger; on a tie node_b's root joins node_a's
    if (grp_size[ra] < grp_size[rb]) begin
      link_to[ra] = rb;
      is_root[ra] = 1'b0;
      grp_size[rb] += grp_size[ra];
    end else begin
      link_to[rb] = ra;
      is_root[rb] = 1'b0;
      grp_size[ra] += grp_size[rb];
    end
    v.acc = 1'b1;
    v.ta = a;
    v.tb = b;
    v.tw = w;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: one transaction per done strobe
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst && done) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result acc=%0b a=%0d b=%0d w=%h", $time,
                 accepted, tree_a, tree_b, tree_weight);
        n_mismatch++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (accepted !== exp_v.acc) begin
          $display("%0t: accepted exp %0b got %0b", $time, exp_v.acc, accepted);
          n_mismatch++;
        end
        if (tree_a !== exp_v.ta) begin
          $display("%0t: tree_a exp %0d got %0d", $time, exp_v.ta, tree_a);
          n_mismatch++;
        end
        if (tree_b !== exp_v.tb) begin
          $display("%0t: tree_b exp %0d got %0d", $time, exp_v.tb, tree_b);
          n_mismatch++;
        end
        if (tree_weight !== exp_v.tw) begin
          $display("%0t: tree_weight exp %h got %h", $time, exp_v.tw, tree_weight);
          n_mismatch++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: one transaction, with random idle cycles ahead of it
  // ---------------------------------------------------------------------------
  task automatic offer_item(input logic act, input logic [NODE_W-1:0] a,
                            input logic [NODE_W-1:0] b, input logic [WEIGHT_W-1:0] w);
    verdict_t v;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    action <= act;
    node_a <= a;
    node_b <= b;
    weight <= w;
    do @(posedge clk); while (busy);
    v = judge_edge(act, a, b, w);
    pending_verdicts = {pending_verdicts, v};
    n_offered++;
    if (act == ACT_CLEAR) n_clears++;
    else if (v.acc) n_tree_edges++;
    else n_rejected++;
  endtask

  task automatic offer_edge(input int a, input int b, input logic [WEIGHT_W-1:0] w);
    offer_item(ACT_EDGE, a[NODE_W-1:0], b[NODE_W-1:0], w);
  endtask

  task automatic offer_clear();
    offer_item(ACT_CLEAR, NODE_W'($urandom), NODE_W'($urandom), $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    offer_clear();
    offer_edge(0, 127, 32'h0000_0000);   // zero weight: no edge
    offer_edge(9, 9, 32'h0001_0000);     // self loop
    offer_edge(0, 127, 32'h0000_0001);   // extreme nodes, smallest weight
    offer_edge(127, 0, 32'h0000_0002);   // same set now
    offer_edge(3, 4, 32'h0001_8000);     // tie: 4 joins 3
    offer_edge(5, 4, 32'h0002_0000);     // single joins the pair
    offer_edge(4, 5, 32'h0002_0001);     // cycle
    offer_edge(6, 7, 32'h0003_0000);
    offer_edge(7, 3, 32'h0003_4000);     // pair joins triple, from node_b side
    offer_edge(6, 5, 32'h0004_0000);     // cycle through compressed paths
    offer_edge(0, 6, 32'h0004_0000);     // two sets of different sizes
    offer_edge(85, 42, 32'hAAAA_5555);   // alternating bits
    offer_edge(42, 85, 32'h5555_AAAA);
    offer_edge(127, 85, 32'hFFFF_FFFF);  // largest weight
    offer_edge(1, 2, 32'h0000_0000);     // zero weight, no state change
    offer_edge(1, 2, 32'hFFFF_FFFF);
    offer_clear();
    offer_edge(127, 0, 32'h0000_0001);   // sets are singletons again
    offer_edge(4, 5, 32'h0000_0002);
    offer_item(ACT_CLEAR, 7'h7F, 7'h7F, 32'hFFFF_FFFF);
    offer_edge(5, 4, 32'h0000_0003);
  endtask

  // Random forests: clear, then ascending-weight edges over a node window,
  // mixed with a little noise (clears, zero weights, random items).
  task automatic test_random_forests(input int idle, input int count);
    int span, base, n_edges, sent;
    logic [WEIGHT_W-1:0] w;
    idle_pct = idle;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 30) span = NODES;
      else span = $urandom_range(2, 16);
      base = $urandom_range(0, NODES - span);
      n_edges = $urandom_range(span, 3 * span);
      if ($urandom_range(3) == 0) w = $urandom_range(1, 32'h7FFF_FFFF);
      else w = $urandom_range(1, 255);
      offer_clear();
      sent++;
      for (int i = 0; i < n_edges && sent < count; i++) begin
        if ($urandom_range(99) < 12) begin
          offer_item(1'($urandom), NODE_W'($urandom), NODE_W'($urandom),
                     ($urandom_range(1) == 0) ? 32'h0 : $urandom);
        end else begin
          w = w + $urandom_range(0, 32'h0001_0000);
          offer_edge(base + $urandom_range(0, span - 1), base + $urandom_range(0, span - 1), w);
        end
        sent++;
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    reset_sets();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_forests(0, 170);
    test_random_forests(76, 170);
    test_random_forests(11, 170);
    drain_results();

    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_verdicts.size());
      n_mismatch++;
    end
    $display("covered %0d transactions: %0d tree edges, %0d rejected edges, %0d clears",
             n_offered, n_tree_edges, n_rejected, n_clears);
    $display("idle-free, heavy-idle and light-idle sender phases; %0d mismatches",
             n_mismatch);
    if (n_mismatch == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/kuf_pkg.sv
hw/rtl/kruskal_union_find_edge_filter.sv
test/kruskal_union_find_edge_filter_tb.sv
